// ===== rtl/pcnl_pkg.sv =====
// Shared types and constants for the polygon face normal line block.
`timescale 1ns / 1ps
package pcnl_pkg;

    localparam int COORD_W     = 24;
    localparam int LEN_W       = 23;
    localparam int DEN_W       = 31;
    localparam int QUO_W       = 24;
    localparam int DIV_W       = DEN_W + QUO_W - 1;
    localparam int NORM_MIN_SQ = 282;

    localparam logic [LEN_W-1:0] LEN_RESET = 23'd4096;
    localparam logic signed [COORD_W-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN = -24'sh800000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/pcnl_front.sv =====
// Front end: accepts vertex beats and accumulates ring sums and Newell normal.
`timescale 1ns / 1ps
module pcnl_front #(
    parameter int MAX_VERT = 256,
    parameter int CW       = 9,
    parameter int PSW      = 33,
    parameter int NSW      = 58,
    parameter int RW       = 282
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  pcnl_pkg::coord_t vertex_x,
    input  pcnl_pkg::coord_t vertex_y,
    input  pcnl_pkg::coord_t vertex_z,
    input  logic            last_in_ring,
    output logic            push_valid,
    input  logic            push_ready,
    output logic [RW-1:0]   push_data
);
    import pcnl_pkg::*;

    typedef enum logic [1:0] {
        F_ACC   = 2'b01,
        F_CLOSE = 2'b10
    } fstate_t;

    fstate_t               state_reg;
    coord_t                first_reg [3];
    coord_t                prev_reg  [3];
    logic signed [PSW-1:0] psum_reg  [3];
    logic signed [NSW-1:0] nsum_reg  [3];
    logic [CW-1:0]         count_reg;
    logic                  ovf_reg;

    coord_t                v [3];
    coord_t                b [3];
    logic signed [49:0]    p [3];
    logic signed [NSW-1:0] nsum_next [3];
    logic                  accept;
    logic                  ring_ok;

    function automatic logic signed [49:0] edge_term(coord_t ad, coord_t bd,
                                                     coord_t as, coord_t bs);
        logic signed [24:0] d;
        logic signed [24:0] s;
        d = ad - bd;
        s = as + bs;
        return d * s;
    endfunction

    assign v[0] = vertex_x;
    assign v[1] = vertex_y;
    assign v[2] = vertex_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            b[k] = (state_reg == F_CLOSE) ? first_reg[k] : v[k];
        end
        p[0] = edge_term(prev_reg[1], b[1], prev_reg[2], b[2]);
        p[1] = edge_term(prev_reg[2], b[2], prev_reg[0], b[0]);
        p[2] = edge_term(prev_reg[0], b[0], prev_reg[1], b[1]);
        for (int k = 0; k < 3; k++)
        begin
            nsum_next[k] = nsum_reg[k] + NSW'(p[k]);
        end
    end

    assign in_stall   = (state_reg == F_CLOSE);
    assign accept     = in_valid && !in_stall;
    assign ring_ok    = !ovf_reg && (count_reg >= CW'(3));
    assign push_valid = (state_reg == F_CLOSE) && ring_ok;
    assign push_data  = {count_reg, psum_reg[2], psum_reg[1], psum_reg[0],
                         nsum_next[2], nsum_next[1], nsum_next[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_ACC;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                first_reg[k] <= '0;
                prev_reg[k]  <= '0;
                psum_reg[k]  <= '0;
                nsum_reg[k]  <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                F_ACC:
                begin
                    if (accept)
                    begin
                        if (count_reg >= CW'(MAX_VERT))
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                if (count_reg == '0)
                                begin
                                    first_reg[k] <= v[k];
                                end
                                else
                                begin
                                    nsum_reg[k] <= nsum_next[k];
                                end
                                prev_reg[k] <= v[k];
                                psum_reg[k] <= psum_reg[k] + PSW'(v[k]);
                            end
                            count_reg <= count_reg + 1'b1;
                        end
                        if (last_in_ring)
                        begin
                            state_reg <= F_CLOSE;
                        end
                    end
                end
                F_CLOSE:
                begin
                    if (!ring_ok || push_ready)
                    begin
                        state_reg <= F_ACC;
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        for (int k = 0; k < 3; k++)
                        begin
                            first_reg[k] <= '0;
                            prev_reg[k]  <= '0;
                            psum_reg[k]  <= '0;
                            nsum_reg[k]  <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_ACC;
                end
            endcase
        end
    end

endmodule

// ===== rtl/pcnl_fifo.sv =====
// Two-entry queue of ring records between front and back end.
`timescale 1ns / 1ps
module pcnl_fifo #(
    parameter int W = 282
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);
    import pcnl_pkg::*;

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/pcnl_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcnl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pcnl_pkg::div_req_t req,
    output pcnl_pkg::div_rsp_t rsp
);
    import pcnl_pkg::*;

    localparam int SCW = $clog2(QUO_W);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dsh_reg;
    logic [QUO_W-1:0] q_reg;
    logic [SCW-1:0]   step_reg;
    logic             busy_reg;
    logic             done_reg;

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            dsh_reg <= {req.divisor, {(QUO_W-1){1'b0}}};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QUO_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (step_reg == SCW'(QUO_W - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SCW'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/pcnl_back.sv =====
// Back end: normal scaling, square root, centroid and offset division, output beat.
`timescale 1ns / 1ps
module pcnl_back #(
    parameter int CW  = 9,
    parameter int PSW = 33,
    parameter int NSW = 58,
    parameter int RW  = 282
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  logic [RW-1:0]      pop_data,
    input  pcnl_pkg::len_t     len,
    output pcnl_pkg::div_req_t div_req,
    input  pcnl_pkg::div_rsp_t div_rsp,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_stall,
    output pcnl_pkg::coord_t   center_x,
    output pcnl_pkg::coord_t   center_y,
    output pcnl_pkg::coord_t   center_z,
    output pcnl_pkg::coord_t   tip_x,
    output pcnl_pkg::coord_t   tip_y,
    output pcnl_pkg::coord_t   tip_z
);
    import pcnl_pkg::*;

    typedef enum logic [9:0] {
        B_IDLE   = 10'b0000000001,
        B_CHK    = 10'b0000000010,
        B_SHIFT  = 10'b0000000100,
        B_SQR    = 10'b0000001000,
        B_SUM    = 10'b0000010000,
        B_ROOT   = 10'b0000100000,
        B_PREP   = 10'b0001000000,
        B_DSTART = 10'b0010000000,
        B_DWAIT  = 10'b0100000000,
        B_FIN    = 10'b1000000000
    } bstate_t;

    bstate_t               state_reg;
    logic signed [PSW-1:0] ps_reg   [3];
    logic [NSW-1:0]        m_reg    [3];
    logic                  ng_reg   [3];
    logic [CW-1:0]         cnt_reg;
    logic [59:0]           sq_reg   [3];
    logic [63:0]           sv_reg;
    logic [63:0]           sr_reg;
    logic [63:0]           sb_reg;
    logic [4:0]            step_reg;
    logic [2:0]            job_reg;
    logic [52:0]           prod_reg;
    coord_t                c_reg    [3];
    logic signed [24:0]    off_reg  [3];
    logic                  ov_reg;
    coord_t                cx_reg, cy_reg, cz_reg, tx_reg, ty_reg, tz_reg;

    logic signed [NSW-1:0] ns_in [3];
    logic [NSW-1:0]        mx;
    logic                  small_mag;
    logic [11:0]           small_sq;
    logic [63:0]           root_t;
    logic [1:0]            k;
    logic                  is_off;
    logic [PSW-1:0]        ps_mag;
    logic [30:0]           ln;
    logic [QUO_W-1:0]      q;
    coord_t                tip [3];
    logic signed [25:0]    tsum;
    logic                  fin_load;

    assign ns_in[0] = pop_data[NSW-1:0];
    assign ns_in[1] = pop_data[2*NSW-1:NSW];
    assign ns_in[2] = pop_data[3*NSW-1:2*NSW];

    assign is_off = (job_reg >= 3'd3);
    assign k      = is_off ? 2'(job_reg - 3'd3) : job_reg[1:0];
    assign ln     = sr_reg[30:0];
    assign q      = div_rsp.quotient;
    assign ps_mag = ps_reg[k][PSW-1] ? PSW'(-ps_reg[k]) : PSW'(ps_reg[k]);
    assign root_t = sr_reg + sb_reg;
    assign fin_load = (state_reg == B_FIN) && (!ov_reg || !out_stall);

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
        begin
            mx = m_reg[1];
        end
        if (m_reg[2] > mx)
        begin
            mx = m_reg[2];
        end
        small_mag = (mx < NSW'(32));
        small_sq  = 12'(m_reg[0][4:0] * m_reg[0][4:0]) + 12'(m_reg[1][4:0] * m_reg[1][4:0])
                  + 12'(m_reg[2][4:0] * m_reg[2][4:0]);
    end

    always_comb
    begin
        div_req.start = (state_reg == B_DSTART);
        if (is_off)
        begin
            div_req.dividend = DIV_W'(prod_reg) + DIV_W'(ln >> 1);
            div_req.divisor  = ln;
        end
        else
        begin
            div_req.dividend = DIV_W'(ps_mag) + DIV_W'(cnt_reg >> 1);
            div_req.divisor  = DEN_W'(cnt_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tsum = 26'(c_reg[i]) + 26'(off_reg[i]);
            if (tsum > 26'(Q_MAX))
            begin
                tip[i] = Q_MAX;
            end
            else if (tsum < 26'(Q_MIN))
            begin
                tip[i] = Q_MIN;
            end
            else
            begin
                tip[i] = tsum[23:0];
            end
        end
    end

    assign pop_ready = (state_reg == B_IDLE);
    assign busy      = (state_reg != B_IDLE);
    assign out_valid = ov_reg;
    assign center_x  = cx_reg;
    assign center_y  = cy_reg;
    assign center_z  = cz_reg;
    assign tip_x     = tx_reg;
    assign tip_y     = ty_reg;
    assign tip_z     = tz_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                cnt_reg <= pop_data[RW-1:RW-CW];
                for (int i = 0; i < 3; i++)
                begin
                    ps_reg[i] <= pop_data[3*NSW+(i+1)*PSW-1 -: PSW];
                    m_reg[i]  <= ns_in[i][NSW-1] ? NSW'(-ns_in[i]) : NSW'(ns_in[i]);
                    ng_reg[i] <= ns_in[i][NSW-1];
                end
            end
            B_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mx >= NSW'(64'd1 << 38))
                    begin
                        m_reg[i] <= m_reg[i] >> 8;
                    end
                    else if (mx >= NSW'(64'd1 << 30))
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                    else if (mx < NSW'(64'd1 << 21))
                    begin
                        m_reg[i] <= m_reg[i] << 8;
                    end
                    else if (mx < NSW'(64'd1 << 29))
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
            end
            B_SQR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= m_reg[i][29:0] * m_reg[i][29:0];
                end
            end
            B_SUM:
            begin
                sv_reg   <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
                sr_reg   <= '0;
                sb_reg   <= 64'd1 << 62;
                step_reg <= '0;
                job_reg  <= '0;
            end
            B_ROOT:
            begin
                if (sv_reg >= root_t)
                begin
                    sv_reg <= sv_reg - root_t;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sb_reg   <= sb_reg >> 2;
                step_reg <= step_reg + 1'b1;
            end
            B_PREP:
            begin
                prod_reg <= m_reg[k][29:0] * len;
            end
            B_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (is_off)
                    begin
                        off_reg[k] <= ng_reg[k] ? -$signed({1'b0, q}) : $signed({1'b0, q});
                    end
                    else
                    begin
                        c_reg[k] <= ps_reg[k][PSW-1] ? -q : q;
                    end
                    job_reg <= job_reg + 1'b1;
                end
            end
            B_FIN:
            begin
                if (fin_load)
                begin
                    cx_reg <= c_reg[0];
                    cy_reg <= c_reg[1];
                    cz_reg <= c_reg[2];
                    tx_reg <= tip[0];
                    ty_reg <= tip[1];
                    tz_reg <= tip[2];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (fin_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        state_reg <= B_CHK;
                    end
                end
                B_CHK:
                begin
                    if (small_mag && (small_sq < 12'(NORM_MIN_SQ)))
                    begin
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        state_reg <= B_SHIFT;
                    end
                end
                B_SHIFT:
                begin
                    if ((mx < NSW'(64'd1 << 30)) && (mx >= NSW'(64'd1 << 29)))
                    begin
                        state_reg <= B_SQR;
                    end
                end
                B_SQR:
                begin
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    state_reg <= B_ROOT;
                end
                B_ROOT:
                begin
                    if (step_reg == 5'd31)
                    begin
                        state_reg <= B_PREP;
                    end
                end
                B_PREP:
                begin
                    state_reg <= B_DSTART;
                end
                B_DSTART:
                begin
                    state_reg <= B_DWAIT;
                end
                B_DWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= (job_reg == 3'd5) ? B_FIN : B_PREP;
                    end
                end
                B_FIN:
                begin
                    if (fin_load)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/polygon_face_normal_line.sv =====
// Polygon face normal line: centroid and scaled Newell normal tip per vertex ring.
// Front end takes one vertex beat per cycle unless in_stall is high while it closes a ring.
// Back end works each ring through normalizing shifts, a 32-step square
// root and six 24-step divisions on one shared divider; it takes a new ring only when idle.
// A two-entry ring queue decouples the two; results leave through an output register.
// Reset (rst_n low, asynchronous) clears ring state and sets the normal length to 4096.
`timescale 1ns / 1ps
module polygon_face_normal_line #(
    parameter int MAX_RING_VERTICES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  pcnl_pkg::len_t   normal_length,
    input  logic             in_valid,
    output logic             in_stall,
    input  pcnl_pkg::coord_t vertex_x,
    input  pcnl_pkg::coord_t vertex_y,
    input  pcnl_pkg::coord_t vertex_z,
    input  logic             last_in_ring,
    output logic             out_valid,
    input  logic             out_stall,
    output pcnl_pkg::coord_t center_x,
    output pcnl_pkg::coord_t center_y,
    output pcnl_pkg::coord_t center_z,
    output pcnl_pkg::coord_t tip_x,
    output pcnl_pkg::coord_t tip_y,
    output pcnl_pkg::coord_t tip_z
);
    import pcnl_pkg::*;

    localparam int CW  = $clog2(MAX_RING_VERTICES + 1);
    localparam int PSW = 25 + $clog2(MAX_RING_VERTICES);
    localparam int NSW = 50 + $clog2(MAX_RING_VERTICES);
    localparam int RW  = CW + 3 * PSW + 3 * NSW;

    len_t          len_reg;
    logic          push_valid;
    logic          push_ready;
    logic [RW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [RW-1:0] pop_data;
    div_req_t      div_req;
    div_rsp_t      div_rsp;
    logic          back_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg <= normal_length;
        end
    end

    pcnl_front #(
        .MAX_VERT (MAX_RING_VERTICES),
        .CW       (CW),
        .PSW      (PSW),
        .NSW      (NSW),
        .RW       (RW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .last_in_ring (last_in_ring),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    pcnl_fifo #(
        .W (RW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pcnl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pcnl_back #(
        .CW  (CW),
        .PSW (PSW),
        .NSW (NSW),
        .RW  (RW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .len       (len_reg),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .center_x  (center_x),
        .center_y  (center_y),
        .center_z  (center_z),
        .tip_x     (tip_x),
        .tip_y     (tip_y),
        .tip_z     (tip_z)
    );

    a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_in_ring |=> in_stall)
        else $error("no ring close cycle after last vertex");

    a_out_from_back: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_busy))
        else $error("result beat without back end work");

    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_ready |=> push_valid)
        else $error("ring record dropped while queue full");

endmodule

// ===== test/polygon_face_normal_line_test.sv =====
// Testbench for polygon_face_normal_line: directed table, random rings, self-checking predictor.
`timescale 1ns / 1ps
module polygon_face_normal_line_test;
    import pcnl_pkg::*;

    localparam int MAX_RING = 256;
    localparam int DRAIN_CYCLES = 600;
    localparam int ROW_PREDICT = 0;
    localparam int ROW_LINE = 1;
    localparam int ROW_NONE = 2;
    localparam longint NORM_SQ_MIN = 282;

    typedef struct {
        coord_t c[3];
        coord_t t[3];
    } line_t;

    typedef struct {
        int x, y, z;
        bit last;
        int kind;
        int cx, cy, cz, tx, ty, tz;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    len_t normal_length = LEN_RESET;
    logic in_valid = 1'b0;
    logic in_stall;
    coord_t vertex_x = '0;
    coord_t vertex_y = '0;
    coord_t vertex_z = '0;
    logic last_in_ring = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    coord_t center_x, center_y, center_z, tip_x, tip_y, tip_z;

    polygon_face_normal_line #(.MAX_RING_VERTICES(MAX_RING)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .normal_length(normal_length),
        .in_valid(in_valid), .in_stall(in_stall),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .last_in_ring(last_in_ring),
        .out_valid(out_valid), .out_stall(out_stall),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .tip_x(tip_x), .tip_y(tip_y), .tip_z(tip_z)
    );

    always #2 clk = ~clk;

    // ring state mirror
    longint first_v[3], prev_v[3], pos_sum[3], newell_sum[3];
    int ring_len;
    bit ring_ovf;
    longint line_len;
    line_t pending_lines[$];
    int errors = 0;
    int burst_left = 0;
    bit typed_row = 0;
    line_t typed_line;

    task report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint unsigned umag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint round_quot(longint unsigned mag, bit neg, longint unsigned den);
        longint unsigned q;
        q = (mag + den / 2) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic void add_edge(longint a[3], longint b[3]);
        newell_sum[0] += (a[1] - b[1]) * (a[2] + b[2]);
        newell_sum[1] += (a[2] - b[2]) * (a[0] + b[0]);
        newell_sum[2] += (a[0] - b[0]) * (a[1] + b[1]);
    endfunction

    function automatic void clear_ring();
        for (int i = 0; i < 3; i++)
        begin
            first_v[i] = 0; prev_v[i] = 0; pos_sum[i] = 0; newell_sum[i] = 0;
        end
        ring_len = 0;
        ring_ovf = 0;
    endfunction

    // returns 1 and fills ln when the vertex closes a ring with a result
    function automatic bit predict_line(coord_t x, coord_t y, coord_t z, bit last,
                                        output line_t ln);
        longint v[3];
        longint unsigned m[3], mx, sq, root;
        bit ng[3];
        bit got;
        longint c, off;
        got = 0;
        v[0] = x; v[1] = y; v[2] = z;
        if (ring_len >= MAX_RING)
            ring_ovf = 1;
        else
        begin
            if (ring_len == 0)
                for (int i = 0; i < 3; i++) first_v[i] = v[i];
            else
                add_edge(prev_v, v);
            for (int i = 0; i < 3; i++)
            begin
                prev_v[i] = v[i];
                pos_sum[i] += v[i];
            end
            ring_len++;
        end
        if (!last) return 0;
        if (!ring_ovf && ring_len >= 3)
        begin
            add_edge(prev_v, first_v);
            for (int i = 0; i < 3; i++)
            begin
                m[i] = umag(newell_sum[i]);
                ng[i] = newell_sum[i] < 0;
            end
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            sq = NORM_SQ_MIN;
            if (mx < (64'd1 << 30)) sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            if (sq >= NORM_SQ_MIN)
            begin
                while (mx >= (64'd1 << 30))
                begin
                    for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
                    mx = mx >> 1;
                end
                while (mx < (64'd1 << 29))
                begin
                    for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
                    mx = mx << 1;
                end
                root = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
                for (int i = 0; i < 3; i++)
                begin
                    c = round_quot(umag(pos_sum[i]), pos_sum[i] < 0, ring_len);
                    off = round_quot(m[i] * longint'(line_len), ng[i], root);
                    ln.c[i] = coord_t'(c);
                    ln.t[i] = coord_t'(sat_coord(c + off));
                end
                got = 1;
            end
        end
        clear_ring();
        return got;
    endfunction

    task send_vertex(coord_t x, coord_t y, coord_t z, bit last);
        int gap;
        line_t ln;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        vertex_x = x; vertex_y = y; vertex_z = z; last_in_ring = last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (predict_line(x, y, z, last, ln))
        begin
            if (typed_row) ln = typed_line;
            pending_lines.insert(pending_lines.size(), ln);
        end
        else if (typed_row && last)
            pending_lines.insert(pending_lines.size(), typed_line);
    endtask

    task write_length(len_t v);
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_lines.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        normal_length = v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        line_len = longint'(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic coord_t rand_coord(int kind);
        case (kind)
            0: return coord_t'(int'($urandom_range(0, 40000)) - 20000);
            1: return coord_t'($urandom);
            default:
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    default: return coord_t'(-1);
                endcase
        endcase
    endfunction

    task send_ring(int n);
        int kind;
        coord_t bx, by, bz;
        kind = $urandom_range(0, 9);
        kind = kind < 6 ? 0 : (kind < 9 ? 1 : 2);
        bx = rand_coord(kind); by = rand_coord(kind); bz = rand_coord(kind);
        for (int i = 0; i < n; i++)
        begin
            // occasional repeat of one base point
            if ($urandom_range(0, 30) == 0)
                send_vertex(bx, by, bz, i == n - 1);
            else
                send_vertex(rand_coord(kind), rand_coord(kind), rand_coord(kind), i == n - 1);
        end
    endtask

    task random_phase(int items, bit with_big);
        int sent, n;
        sent = 0;
        if (with_big)
        begin
            send_ring(MAX_RING);
            send_ring(MAX_RING + 2);
        end
        while (sent < items)
        begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(1, 2);
                1, 2, 3, 4: n = 3;
                default: n = $urandom_range(4, 9);
            endcase
            send_ring(n);
            sent += n;
        end
    endtask

    row_t rows[] = '{
        '{0, 0, 0, 0, ROW_LINE, 1365, 1365, 0, 1365, 1365, 4096},
        '{4096, 0, 0, 0, ROW_LINE, 1365, 1365, 0, 1365, 1365, 4096},
        '{0, 4096, 0, 1, ROW_LINE, 1365, 1365, 0, 1365, 1365, 4096},
        '{100, 200, 300, 1, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{5, 5, 5, 0, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{-5, 7, 9, 1, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{1000, 1000, 1000, 0, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{1000, 1000, 1000, 0, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{1000, 1000, 1000, 1, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{4096, 4096, 4096, 0, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{8192, 8192, 8192, 1, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{8388607, 8388607, 8388607, 0, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{-8388608, 8388607, -8388608, 0, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{8388607, -8388608, -8388608, 1, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{-8388608, -8388608, 0, 0, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{8388607, -8388608, 0, 0, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{8388607, 8388607, 0, 0, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{-8388608, 8388607, 0, 1, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{0, 16, 0, 1, ROW_NONE, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, ROW_PREDICT, 0, 0, 0, 0, 0, 0},
        '{0, 17, 0, 1, ROW_PREDICT, 0, 0, 0, 0, 0, 0}
    };

    // receiver stall pattern, mode drawn anew each time stall_tick wraps to zero
    int stall_mode = 0;
    int stall_tick = 0;
    always @(negedge clk)
    begin
        if (stall_tick == 0) stall_mode = $urandom_range(0, 3);
        stall_tick = (stall_tick + 1) % 64;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= (stall_tick % 5) < 2;
        endcase
    end

    always @(posedge clk)
    begin
        line_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_lines.size() == 0)
            begin
                report("unexpected beat", 1, 0);
            end
            else
            begin
                want = pending_lines.pop_front();
                if (center_x !== want.c[0]) report("center_x", center_x, want.c[0]);
                if (center_y !== want.c[1]) report("center_y", center_y, want.c[1]);
                if (center_z !== want.c[2]) report("center_z", center_z, want.c[2]);
                if (tip_x !== want.t[0]) report("tip_x", tip_x, want.t[0]);
                if (tip_y !== want.t[1]) report("tip_y", tip_y, want.t[1]);
                if (tip_z !== want.t[2]) report("tip_z", tip_z, want.t[2]);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        line_len = longint'(LEN_RESET);
        clear_ring();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            typed_row = rows[i].kind != ROW_PREDICT;
            typed_line.c[0] = coord_t'(rows[i].cx); typed_line.c[1] = coord_t'(rows[i].cy);
            typed_line.c[2] = coord_t'(rows[i].cz); typed_line.t[0] = coord_t'(rows[i].tx);
            typed_line.t[1] = coord_t'(rows[i].ty); typed_line.t[2] = coord_t'(rows[i].tz);
            if (rows[i].kind == ROW_NONE && rows[i].last)
            begin
                // no result expected: predictor must agree, so drop the typed push
                typed_row = 0;
            end
            send_vertex(coord_t'(rows[i].x), coord_t'(rows[i].y), coord_t'(rows[i].z),
                        rows[i].last);
        end
        typed_row = 0;

        write_length('0);
        random_phase(230, 0);
        write_length(23'h7FFFFF);
        random_phase(230, 1);
        write_length(23'd1);
        random_phase(230, 0);
        write_length(len_t'($urandom));
        random_phase(230, 0);
        write_length(LEN_RESET);
        random_phase(230, 0);

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_lines.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
